// ===== src/bpq_pkg.sv =====
// Shared types and constants for the bucket priority queue.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bpq_pkg;

   localparam int NUM_KEYS_DEF = 1024;
   localparam int CAPACITY_DEF = 1024;

   // occupancy is kept as rows of 2**ROW_BITS bucket bits
   localparam int ROW_BITS = 5;
   localparam int ROW_SIZE = 1 << ROW_BITS;

   localparam logic [1:0] FUNC_PUSH  = 2'd0;
   localparam logic [1:0] FUNC_POP   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_KEY_HIGH = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic       latch;        // capture request fields
      logic       dec_rd;       // first reads of a push or a pop
      logic       push_wr;      // push commit
      logic       pop_head;     // read head and tail of the served bucket
      logic       pop_ent;      // read the entry, update occupancy
      logic       pop_fin;      // pop commit
      logic       clear;
      logic       rsp_load;
      logic       rsp_payload;  // response carries the popped entry
      logic [1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       key_high;
      logic       full;
      logic       empty;
      logic       out_free;
   } stat_type;

endpackage

// ===== src/bpq_ctrl.sv =====
// Sequencer for the bucket priority queue: decodes each transaction and
// steps the datapath through it. Depends on bpq_pkg.
`timescale 1ns / 1ps

module bpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bpq_pkg::stat_type  stat,
   output bpq_pkg::cmd_type   cmd
);
   import bpq_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_PUSH_WR  = 3'd2;
   localparam logic [2:0] S_POP_HEAD = 3'd3;
   localparam logic [2:0] S_POP_ENT  = 3'd4;
   localparam logic [2:0] S_POP_FIN  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.func)
               FUNC_PUSH: begin
                  if (stat.key_high || stat.full) begin
                     cmd.rsp_status = stat.key_high ? ST_KEY_HIGH : ST_FULL;
                     if (stat.out_free) begin
                        cmd.rsp_load = 1'b1;
                        state_in     = S_IDLE;
                     end
                  end else begin
                     cmd.dec_rd = 1'b1;
                     state_in   = S_PUSH_WR;
                  end
               end
               FUNC_POP: begin
                  if (stat.empty) begin
                     cmd.rsp_status = ST_EMPTY;
                     if (stat.out_free) begin
                        cmd.rsp_load = 1'b1;
                        state_in     = S_IDLE;
                     end
                  end else begin
                     cmd.dec_rd = 1'b1;
                     state_in   = S_POP_HEAD;
                  end
               end
               FUNC_CLEAR: begin
                  if (stat.out_free) begin
                     cmd.clear    = 1'b1;
                     cmd.rsp_load = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  if (stat.out_free) begin
                     cmd.rsp_load = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         S_PUSH_WR: begin
            if (stat.out_free) begin
               cmd.push_wr  = 1'b1;
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_POP_HEAD: begin
            cmd.pop_head = 1'b1;
            state_in     = S_POP_ENT;
         end
         S_POP_ENT: begin
            cmd.pop_ent = 1'b1;
            state_in    = S_POP_FIN;
         end
         S_POP_FIN: begin
            if (stat.out_free) begin
               cmd.pop_fin     = 1'b1;
               cmd.rsp_load    = 1'b1;
               cmd.rsp_payload = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== src/bpq_datapath.sv =====
// Datapath of the bucket priority queue: entry store, bucket lists,
// occupancy rows, free list and response register. Depends on bpq_pkg.
`timescale 1ns / 1ps

module bpq_datapath #(
   parameter int NUM_KEYS = bpq_pkg::NUM_KEYS_DEF,
   parameter int CAPACITY = bpq_pkg::CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_cost,
   input  logic [31:0]        req_parent_id,
   input  logic [31:0]        req_op_handle,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_out_parent_id,
   output logic [31:0]        rsp_out_op_handle,
   input  bpq_pkg::cmd_type   cmd,
   output bpq_pkg::stat_type  stat
);
   import bpq_pkg::*;

   localparam int NROWS = (NUM_KEYS + ROW_SIZE - 1) / ROW_SIZE;
   localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
   localparam int KIW   = RW + ROW_BITS;
   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = AW + 1;

   // memories
   logic [63:0]         pay_mem  [CAPACITY];
   logic [AW-1:0]       next_mem [CAPACITY];
   logic [AW-1:0]       head_mem [NROWS*ROW_SIZE];
   logic [AW-1:0]       tail_mem [NROWS*ROW_SIZE];
   logic [ROW_SIZE-1:0] row_mem  [NROWS];

   // request capture
   logic [1:0]  func_ff;
   logic [15:0] cost_ff;
   logic [63:0] pl_ff;

   // control state
   logic [NROWS-1:0] nzsum_ff, nzsum_in;   // row holds any nonempty bucket
   logic [AW-1:0]    free_head_ff, free_head_in;
   logic [CW-1:0]    fresh_ff, fresh_in;   // first never-allocated entry
   logic [CW-1:0]    count_ff, count_in;

   // read data and pop context
   logic [ROW_SIZE-1:0] rowword_ff;
   logic                sumbit_ff;
   logic [RW-1:0]       row_ff;
   logic [AW-1:0]       head_ff, tail_ff, next_ff;
   logic [63:0]         pay_ff;
   logic [KIW-1:0]      key_ff;
   logic [AW-1:0]       idx_ff;
   logic                last_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [63:0] rsp_pl_ff;

   logic [KIW-1:0]      cost_key;
   logic [RW-1:0]       cost_row;
   logic [ROW_BITS-1:0] cost_bit;
   logic [RW-1:0]       srow;
   logic [ROW_BITS-1:0] pbit;
   logic [KIW-1:0]      key_sel;
   logic                bucket_nz;
   logic [ROW_SIZE-1:0] row_base, row_set, row_clr;
   logic [RW-1:0]       rd_row;
   logic [CW-1:0]       fresh_inc;

   assign cost_key = cost_ff[KIW-1:0];
   assign cost_row = cost_key[KIW-1:ROW_BITS];
   assign cost_bit = cost_key[ROW_BITS-1:0];

   assign stat.func     = func_ff;
   assign stat.key_high = ({1'b0, cost_ff} >= 17'(NUM_KEYS));
   assign stat.full     = (count_ff == CW'(CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   // lowest row with a nonempty bucket
   always_comb begin
      srow = '0;
      for (int i = NROWS - 1; i >= 0; i--) begin
         if (nzsum_ff[i]) srow = RW'(i);
      end
   end

   // lowest nonempty bucket inside the fetched row
   always_comb begin
      pbit = '0;
      for (int i = ROW_SIZE - 1; i >= 0; i--) begin
         if (rowword_ff[i]) pbit = ROW_BITS'(i);
      end
   end

   assign key_sel   = {row_ff, pbit};
   assign rd_row    = (func_ff == FUNC_POP) ? srow : cost_row;
   assign bucket_nz = sumbit_ff && rowword_ff[cost_bit];
   assign row_base  = sumbit_ff ? rowword_ff : '0;
   assign row_set   = row_base | (ROW_SIZE'(1) << cost_bit);
   assign row_clr   = rowword_ff & ~(ROW_SIZE'(1) << key_ff[ROW_BITS-1:0]);
   assign fresh_inc = fresh_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff <= req_func;
         cost_ff <= req_cost;
         pl_ff   <= {req_parent_id, req_op_handle};
      end
   end

   // occupancy rows
   always_ff @(posedge clock) begin
      if (cmd.dec_rd) begin
         rowword_ff <= row_mem[rd_row];
         row_ff     <= rd_row;
         sumbit_ff  <= nzsum_ff[rd_row];
      end
      if (cmd.push_wr)
         row_mem[row_ff] <= row_set;
      else if (cmd.pop_ent && tail_ff == head_ff)
         row_mem[row_ff] <= row_clr;
   end

   // bucket heads and tails
   always_ff @(posedge clock) begin
      if (cmd.dec_rd || cmd.pop_head)
         tail_ff <= tail_mem[cmd.pop_head ? key_sel : cost_key];
      if (cmd.pop_head) begin
         head_ff <= head_mem[key_sel];
         key_ff  <= key_sel;
      end
      if (cmd.push_wr)
         tail_mem[cost_key] <= free_head_ff;
      if (cmd.push_wr && !bucket_nz)
         head_mem[cost_key] <= free_head_ff;
      else if (cmd.pop_fin && !last_ff)
         head_mem[key_ff] <= next_ff;
   end

   // entry links and payloads
   always_ff @(posedge clock) begin
      if (cmd.dec_rd || cmd.pop_ent)
         next_ff <= next_mem[cmd.pop_ent ? head_ff : free_head_ff];
      if (cmd.push_wr && bucket_nz)
         next_mem[tail_ff] <= free_head_ff;
      else if (cmd.pop_fin)
         next_mem[idx_ff] <= free_head_ff;
      if (cmd.pop_ent) begin
         pay_ff  <= pay_mem[head_ff];
         idx_ff  <= head_ff;
         last_ff <= (tail_ff == head_ff);
      end
      if (cmd.push_wr)
         pay_mem[free_head_ff] <= pl_ff;
   end

   always_comb begin
      nzsum_in     = nzsum_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      count_in     = count_ff;
      if (cmd.clear) begin
         nzsum_in     = '0;
         free_head_in = '0;
         fresh_in     = '0;
         count_in     = '0;
      end else if (cmd.push_wr) begin
         nzsum_in[row_ff] = 1'b1;
         count_in         = count_ff + CW'(1);
         if ({1'b0, free_head_ff} == fresh_ff) begin
            // free list runs into the untouched region, linked in order
            fresh_in     = fresh_inc;
            free_head_in = (fresh_inc == CW'(CAPACITY)) ? '0 : fresh_inc[AW-1:0];
         end else begin
            free_head_in = next_ff;
         end
      end else if (cmd.pop_ent) begin
         if (tail_ff == head_ff) nzsum_in[row_ff] = |row_clr;
      end else if (cmd.pop_fin) begin
         free_head_in = idx_ff;
         count_in     = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nzsum_ff     <= '0;
         free_head_ff <= '0;
         fresh_ff     <= '0;
         count_ff     <= '0;
      end else begin
         nzsum_ff     <= nzsum_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)   rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_pl_ff     <= cmd.rsp_payload ? pay_ff : 64'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_parent_id = rsp_pl_ff[63:32];
   assign rsp_out_op_handle = rsp_pl_ff[31:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY) && fresh_ff <= CW'(CAPACITY))
      else $error("entry count or fresh mark beyond capacity");

   a_empty_rows: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> nzsum_ff == '0)
      else $error("occupancy set while store is empty");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> count_ff == '0 && free_head_ff == '0)
      else $error("clear left entries behind");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.out_free)
      else $error("response overwritten while held");

endmodule

// ===== src/bucket_priority_queue.sv =====
// Bucket priority queue: push, pop-lowest and clear over keyed FIFO buckets.
// Top level; instantiates bpq_ctrl and bpq_datapath, depends on bpq_pkg.
//
// One transaction at a time. A clear, an empty pop or a rejected push is answered at
// decode, a push at the write step and a pop at the commit step after its head and
// entry reads; the pop walks the linked bucket list, whose head, tail, link and
// payload stores each have one registered read port. The lowest bucket is found
// from a one-bit-per-row occupancy summary and one 32-bucket occupancy row. Reset
// and clear take effect at once, with no clearing pass; the free list past the highest
// entry ever used is implied. A new request is taken while a response still waits.
`timescale 1ns / 1ps

module bucket_priority_queue #(
   parameter int NUM_KEYS = bpq_pkg::NUM_KEYS_DEF,
   parameter int CAPACITY = bpq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_cost,
   input  logic [31:0] req_parent_id,
   input  logic [31:0] req_op_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_parent_id,
   output logic [31:0] rsp_out_op_handle
);
   import bpq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bpq_datapath #(
      .NUM_KEYS (NUM_KEYS),
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_cost          (req_cost),
      .req_parent_id     (req_parent_id),
      .req_op_handle     (req_op_handle),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_out_parent_id (rsp_out_parent_id),
      .rsp_out_op_handle (rsp_out_op_handle),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule
